/* src/vat_pkg.sv */
// Shared types, constants and helper functions for the vertex affine transform.
package vat_pkg;

    // Default number of fraction bits of the fixed-point vertex format.
    localparam int FRAC_BITS_DEF = 16;

    // Angle constants in whole degrees.
    localparam int HALF_TURN    = 180;
    localparam int FULL_TURN    = 2 * HALF_TURN;
    localparam int QUARTER_TURN = HALF_TURN / 2;

    // One degree in radians, Q30.
    localparam longint unsigned DEG_Q30 = 64'd18740330;

    // Geometry sizes.
    localparam int N_AXIS = 3;
    localparam int N_COEF = N_AXIS * N_AXIS;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ANGLE_W    = 9;

    typedef logic signed [31:0] t_word;
    typedef t_word t_vec [N_AXIS];
    typedef t_word t_mat [N_COEF];
    typedef logic [31:0] t_sin_tab [QUARTER_TURN + 1];

    // Operating modes; the fourth code passes the vertex through.
    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_SCALE     = 2'd1,
        MODE_ROTATE    = 2'd2,
        MODE_PASS      = 2'd3
    } t_mode;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_PARAM_X = 3'd1,
        CFG_PARAM_Y = 3'd2,
        CFG_PARAM_Z = 3'd3,
        CFG_ANGLE   = 3'd4
    } t_cfg_idx;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic t_word f_sat(input logic signed [65:0] v);
        t_word res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Quarter-wave sine table over whole degrees, rounded to the given
    // fraction width. Built from a Taylor series in Q30 at elaboration.
    function automatic t_sin_tab f_sin_tab(input int frac);
        t_sin_tab          tab;
        logic [63:0]        u;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        for (int d = 0; d <= QUARTER_TURN; d++) begin
            u    = 64'(d) * DEG_Q30;
            x2   = (u * u) >> 30;
            term = u;
            sum  = $signed(u);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (64'sd1 <<< 30)) begin
                sum = 64'sd1 <<< 30;
            end
            rnd    = (sum + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
            tab[d] = rnd[31:0];
        end
        return tab;
    endfunction

endpackage

/* src/vat_matrix.sv */
// Sequencer that builds the axis-angle rotation matrix with one shared multiplier.
module vat_matrix #(
    parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  vat_pkg::t_vec                     i_axis,
    input  logic [vat_pkg::ANGLE_W-1:0]       i_angle,
    output logic                              o_busy,
    output vat_pkg::t_mat                     o_mat
);

    localparam vat_pkg::t_sin_tab SIN_TAB = vat_pkg::f_sin_tab(FRAC_BITS);
    localparam vat_pkg::t_word    ONE     = 32'sd1 <<< FRAC_BITS;

    // Step codes of the build sequence.
    localparam logic [4:0] STEP_T0   = 5'd6;
    localparam logic [4:0] STEP_T1   = 5'd11;
    localparam logic [4:0] STEP_SN0  = 5'd12;
    localparam logic [4:0] STEP_SN1  = 5'd13;
    localparam logic [4:0] STEP_SN2  = 5'd14;
    localparam logic [4:0] STEP_DONE = 5'd16;

    localparam logic [vat_pkg::ANGLE_W-1:0] A_FULL = vat_pkg::ANGLE_W'(vat_pkg::FULL_TURN);
    localparam logic [vat_pkg::ANGLE_W-1:0] A_Q1   = vat_pkg::ANGLE_W'(vat_pkg::QUARTER_TURN);
    localparam logic [vat_pkg::ANGLE_W-1:0] A_Q2   = vat_pkg::ANGLE_W'(vat_pkg::HALF_TURN);
    localparam logic [vat_pkg::ANGLE_W-1:0] A_Q3   =
        vat_pkg::ANGLE_W'(vat_pkg::HALF_TURN + vat_pkg::QUARTER_TURN);
    localparam logic [6:0] RM_MAX = 7'(vat_pkg::QUARTER_TURN);

    logic                      r_busy;
    logic [4:0]                r_step;
    logic                      r_wr;
    logic [3:0]                r_dst;
    logic signed [63:0]        r_prod;
    vat_pkg::t_word            r_scr [vat_pkg::N_COEF];
    vat_pkg::t_word            r_sn;
    vat_pkg::t_word            r_cs;
    vat_pkg::t_word            r_t;
    vat_pkg::t_mat             r_mat;

    logic [vat_pkg::ANGLE_W-1:0] n_ang;
    logic [1:0]                  n_quad;
    logic [6:0]                  n_rm;
    vat_pkg::t_word              n_s0;
    vat_pkg::t_word              n_s1;
    vat_pkg::t_word              n_sn;
    vat_pkg::t_word              n_cs;
    vat_pkg::t_word              n_opa;
    vat_pkg::t_word              n_opb;
    logic [3:0]                  n_dst;

    // Reduce the angle to a quadrant and an offset inside it.
    always_comb begin
        n_ang = (i_angle >= A_FULL) ? i_angle - A_FULL : i_angle;
        if (n_ang < A_Q1) begin
            n_quad = 2'd0;
            n_rm   = n_ang[6:0];
        end else if (n_ang < A_Q2) begin
            n_quad = 2'd1;
            n_rm   = 7'(n_ang - A_Q1);
        end else if (n_ang < A_Q3) begin
            n_quad = 2'd2;
            n_rm   = 7'(n_ang - A_Q2);
        end else begin
            n_quad = 2'd3;
            n_rm   = 7'(n_ang - A_Q3);
        end
        n_s0 = SIN_TAB[n_rm];
        n_s1 = SIN_TAB[RM_MAX - n_rm];
    end

    // Quadrant symmetry for sine and cosine.
    always_comb begin
        case (n_quad)
            2'd0: begin
                n_sn = n_s0;
                n_cs = n_s1;
            end
            2'd1: begin
                n_sn = n_s1;
                n_cs = -n_s0;
            end
            2'd2: begin
                n_sn = -n_s0;
                n_cs = -n_s1;
            end
            default: begin
                n_sn = -n_s1;
                n_cs = n_s0;
            end
        endcase
    end

    // Sine, cosine and one minus cosine are held in registers.
    always_ff @(posedge i_clk) begin
        r_sn <= n_sn;
        r_cs <= n_cs;
        r_t  <= ONE - r_cs;
    end

    // Operand selection for each step of the build.
    always_comb begin
        n_opa = '0;
        n_opb = '0;
        unique case (r_step) inside
            5'd0: begin
                n_opa = i_axis[0];
                n_opb = i_axis[0];
            end
            5'd1: begin
                n_opa = i_axis[0];
                n_opb = i_axis[1];
            end
            5'd2: begin
                n_opa = i_axis[0];
                n_opb = i_axis[2];
            end
            5'd3: begin
                n_opa = i_axis[1];
                n_opb = i_axis[1];
            end
            5'd4: begin
                n_opa = i_axis[1];
                n_opb = i_axis[2];
            end
            5'd5: begin
                n_opa = i_axis[2];
                n_opb = i_axis[2];
            end
            [STEP_T0:STEP_T1]: begin
                n_opa = r_scr[4'(r_step - STEP_T0)];
                n_opb = r_t;
            end
            STEP_SN0: begin
                n_opa = i_axis[2];
                n_opb = r_sn;
            end
            STEP_SN1: begin
                n_opa = i_axis[1];
                n_opb = r_sn;
            end
            STEP_SN2: begin
                n_opa = i_axis[0];
                n_opb = r_sn;
            end
            default: begin
                n_opa = '0;
                n_opb = '0;
            end
        endcase
        n_dst = (r_step < STEP_T0) ? r_step[3:0] : 4'(r_step - STEP_T0);
    end

    // Shared multiplier and write-back of the floored, saturated product.
    always_ff @(posedge i_clk) begin
        r_prod <= n_opa * n_opb;
        r_dst  <= n_dst;
        if (r_wr) begin
            r_scr[r_dst] <= vat_pkg::f_sat($signed({{2{r_prod[63]}}, r_prod}) >>> FRAC_BITS);
        end
    end

    // Step counter; a start restarts the whole build.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_wr   <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_wr   <= 1'b0;
        end else if (r_busy) begin
            r_wr <= (r_step <= STEP_SN2);
            if (r_step == STEP_DONE) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 5'd1;
            end
        end else begin
            r_wr <= 1'b0;
        end
    end

    // Final coefficients: scaled axis products plus cosine or sine terms.
    always_ff @(posedge i_clk) begin
        if (r_busy && (r_step == STEP_DONE) && !i_start) begin
            r_mat[0] <= vat_pkg::f_sat(66'(r_scr[0]) + 66'(r_cs));
            r_mat[1] <= vat_pkg::f_sat(66'(r_scr[1]) - 66'(r_scr[6]));
            r_mat[2] <= vat_pkg::f_sat(66'(r_scr[2]) + 66'(r_scr[7]));
            r_mat[3] <= vat_pkg::f_sat(66'(r_scr[1]) + 66'(r_scr[6]));
            r_mat[4] <= vat_pkg::f_sat(66'(r_scr[3]) + 66'(r_cs));
            r_mat[5] <= vat_pkg::f_sat(66'(r_scr[4]) - 66'(r_scr[8]));
            r_mat[6] <= vat_pkg::f_sat(66'(r_scr[2]) - 66'(r_scr[7]));
            r_mat[7] <= vat_pkg::f_sat(66'(r_scr[4]) + 66'(r_scr[8]));
            r_mat[8] <= vat_pkg::f_sat(66'(r_scr[5]) + 66'(r_cs));
        end
    end

    assign o_busy = r_busy;
    assign o_mat  = r_mat;

endmodule

/* src/vertex_affine_transform.sv */
// Top level: configuration registers and the four-stage vertex pipeline.
// An accepted request passes through the input, product, row-sum and output registers.
// Throughput: one vertex per cycle through nine 32x32 multipliers, while the output
// takes vertices and no matrix build runs. Any configuration write starts a matrix build
// on one shared multiplier, during which no vertex request is accepted.
// Reset clears the registers to zero, empties the pipeline and runs the same build.
module vertex_affine_transform #(
    parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vat_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [vat_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_vin_valid,
    output logic                            o_vin_ready,
    input  logic signed [31:0]              i_vin_x,
    input  logic signed [31:0]              i_vin_y,
    input  logic signed [31:0]              i_vin_z,
    input  logic                            i_vin_last,
    output logic                            o_vout_valid,
    input  logic                            i_vout_ready,
    output logic signed [31:0]              o_vout_x,
    output logic signed [31:0]              o_vout_y,
    output logic signed [31:0]              o_vout_z,
    output logic                            o_vout_last
);

    // Configuration registers.
    vat_pkg::t_mode               r_mode;
    vat_pkg::t_vec                r_param;
    logic [vat_pkg::ANGLE_W-1:0]  r_angle;

    // Pipeline registers.
    logic                  r1_v, r2_v, r3_v, r4_v;
    vat_pkg::t_vec         r1_vtx;
    logic                  r1_last, r2_last, r3_last, r4_last;
    logic signed [63:0]    r2_prod [vat_pkg::N_COEF];
    logic signed [32:0]    r2_sum [vat_pkg::N_AXIS];
    logic signed [65:0]    r3_acc [vat_pkg::N_AXIS];
    vat_pkg::t_vec         r4_out;

    logic                  w_busy;
    vat_pkg::t_mat         w_mat;
    logic                  w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic                  w_accept;
    logic signed [63:0]    n_prod [vat_pkg::N_COEF];
    logic signed [32:0]    n_sum [vat_pkg::N_AXIS];
    logic signed [65:0]    n_acc [vat_pkg::N_AXIS];
    vat_pkg::t_word        n_out [vat_pkg::N_AXIS];

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= vat_pkg::MODE_TRANSLATE;
            r_param <= '{default: '0};
            r_angle <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vat_pkg::CFG_MODE:    r_mode     <= vat_pkg::t_mode'(i_cfg_data[1:0]);
                vat_pkg::CFG_PARAM_X: r_param[0] <= i_cfg_data;
                vat_pkg::CFG_PARAM_Y: r_param[1] <= i_cfg_data;
                vat_pkg::CFG_PARAM_Z: r_param[2] <= i_cfg_data;
                vat_pkg::CFG_ANGLE:   r_angle    <= i_cfg_data[vat_pkg::ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Rotation matrix builder.
    vat_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_axis  (r_param),
        .i_angle (r_angle),
        .o_busy  (w_busy),
        .o_mat   (w_mat)
    );

    // Per-stage ready: a stage loads when empty or when its content moves on.
    assign w_rdy4      = !r4_v || i_vout_ready;
    assign w_rdy3      = !r3_v || w_rdy4;
    assign w_rdy2      = !r2_v || w_rdy3;
    assign w_rdy1      = !r1_v || w_rdy2;
    assign o_vin_ready = w_rdy1 && !w_busy && !i_cfg_we;
    assign w_accept    = i_vin_valid && o_vin_ready;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= w_accept;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    // Stage 1: input register.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_vtx[0] <= i_vin_x;
            r1_vtx[1] <= i_vin_y;
            r1_vtx[2] <= i_vin_z;
            r1_last   <= i_vin_last;
        end
    end

    // Stage 2: nine products and the offset sums.
    always_comb begin
        for (int k = 0; k < vat_pkg::N_COEF; k++) begin
            if (r_mode == vat_pkg::MODE_SCALE) begin
                n_prod[k] = r_param[k % vat_pkg::N_AXIS] * r1_vtx[k % vat_pkg::N_AXIS];
            end else begin
                n_prod[k] = w_mat[k] * r1_vtx[k % vat_pkg::N_AXIS];
            end
        end
        for (int i = 0; i < vat_pkg::N_AXIS; i++) begin
            if (r_mode == vat_pkg::MODE_TRANSLATE) begin
                n_sum[i] = 33'(r1_vtx[i]) + 33'(r_param[i]);
            end else begin
                n_sum[i] = 33'(r1_vtx[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_prod <= n_prod;
            r2_sum  <= n_sum;
            r2_last <= r1_last;
        end
    end

    // Stage 3: row sums, held exact until the single floor.
    always_comb begin
        for (int i = 0; i < vat_pkg::N_AXIS; i++) begin
            case (r_mode)
                vat_pkg::MODE_ROTATE: n_acc[i] = 66'(r2_prod[3*i]) + 66'(r2_prod[3*i+1])
                                               + 66'(r2_prod[3*i+2]);
                vat_pkg::MODE_SCALE:  n_acc[i] = 66'(r2_prod[4*i]);
                default:              n_acc[i] = 66'(r2_sum[i]) <<< FRAC_BITS;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_acc  <= n_acc;
            r3_last <= r2_last;
        end
    end

    // Stage 4: floor by the fraction width, saturate, output register.
    always_comb begin
        for (int i = 0; i < vat_pkg::N_AXIS; i++) begin
            n_out[i] = vat_pkg::f_sat(r3_acc[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_out  <= n_out;
            r4_last <= r3_last;
        end
    end

    assign o_vout_valid = r4_v;
    assign o_vout_x     = r4_out[0];
    assign o_vout_y     = r4_out[1];
    assign o_vout_z     = r4_out[2];
    assign o_vout_last  = r4_last;

    // A configuration write always leaves a matrix build running.
    a_cfg_starts_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_busy)
        else $error("configuration write did not start a matrix build");

    // A full, stalled pipeline takes no new request.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && r2_v && r3_v && r4_v && !i_vout_ready) |-> !o_vin_ready)
        else $error("request accepted into a full pipeline");

    // A stalled middle stage keeps its item and its data.
    a_stage3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !w_rdy4) |=> (r3_v && $stable(r3_acc[0]) && $stable(r3_last)))
        else $error("stalled stage lost or changed its item");

    // An accepted request always lands in the first stage.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r1_v)
        else $error("accepted request missing from first stage");

endmodule
